// ===== src/lcs_pkg.sv =====
// Shared types, constants and codes for the line centroid steering block.
`default_nettype none
package lcs_pkg;

    localparam int LINE_PIXELS_DEFAULT = 128;
    localparam int LINE_FIFO_DEPTH     = 2;

    localparam logic [7:0] BRIGHT_THRESHOLD_RST = 8'd150;
    localparam logic [7:0] MIN_BRIGHT_RST       = 8'd5;
    localparam logic [6:0] LEFT_EDGE_RST        = 7'd58;
    localparam logic [6:0] RIGHT_EDGE_RST       = 7'd80;
    localparam logic [7:0] FULL_WHITE_COUNT_RST = 8'd125;
    localparam logic [9:0] MOTOR_SCALE_RST      = 10'd100;

    // Reciprocal of ten in 16 fraction bits; exact floor for products below 8192.
    localparam logic [12:0] RECIP_TEN = 13'd6554;

    // Wheel magnitudes in tenths of full scale.
    localparam logic [3:0] TENTHS_FAST = 4'd8;
    localparam logic [3:0] TENTHS_MID  = 4'd6;
    localparam logic [3:0] TENTHS_SLOW = 4'd4;
    localparam logic [3:0] TENTHS_STOP = 4'd0;

    localparam logic [7:0] POSITION_LOST = 8'hFF;

    typedef enum logic [2:0] {
        REG_BRIGHT_THRESHOLD = 3'd0,
        REG_MIN_BRIGHT       = 3'd1,
        REG_LEFT_EDGE        = 3'd2,
        REG_RIGHT_EDGE       = 3'd3,
        REG_FULL_WHITE_COUNT = 3'd4,
        REG_MOTOR_SCALE      = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        STEER_LEFT     = 3'd0,
        STEER_RIGHT    = 3'd1,
        STEER_STRAIGHT = 3'd2,
        STEER_STOP     = 3'd3,
        STEER_HOLD     = 3'd4
    } steer_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_DIVIDE,
        BACK_DECIDE,
        BACK_SCALE
    } back_state_t;

    typedef struct packed {
        logic [7:0] bright_threshold;
        logic [7:0] min_bright;
        logic [6:0] left_edge;
        logic [6:0] right_edge;
        logic [7:0] full_white_count;
        logic [9:0] motor_scale;
    } cfg_t;

    // Handshake between a queue and its neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage
`default_nettype wire

// ===== src/lcs_line_fifo.sv =====
// Short queue of finished line records between the accumulator and the steering unit.
`default_nettype none
module lcs_line_fifo #(
    parameter int WIDTH = 21,
    parameter int DEPTH = lcs_pkg::LINE_FIFO_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output lcs_pkg::fifo_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data      = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    // The fill level must never exceed the queue depth.
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("line queue fill level out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && status.full && !rd_en))
        else $error("line queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && status.empty))
        else $error("line queue read while empty");

endmodule
`default_nettype wire

// ===== src/lcs_front.sv =====
// Pixel accumulator: sums bright pixel indices and counts them for each line.
`default_nettype none
module lcs_front #(
    parameter int LINE_PIXELS = lcs_pkg::LINE_PIXELS_DEFAULT,
    parameter int SUM_W       = 13,
    parameter int CNT_W       = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       pixel,
    input  wire logic             last_pixel,
    input  wire logic [7:0]       bright_threshold,
    output logic                  line_done,
    output logic      [SUM_W-1:0] line_sum,
    output logic      [CNT_W-1:0] line_count
);

    localparam int IDX_W = $clog2(LINE_PIXELS + 1);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] sum_acc;
    logic [CNT_W-1:0] cnt_acc;
    logic             in_line;

    always_comb
    begin
        in_line = (idx_reg < IDX_W'(LINE_PIXELS));
        sum_acc = sum_reg;
        cnt_acc = cnt_reg;
        // Pixels beyond the line length are dropped until the line ends.
        if (in_line && (pixel >= bright_threshold))
        begin
            sum_acc = sum_reg + SUM_W'(idx_reg);
            cnt_acc = cnt_reg + 1'b1;
        end
        idx_next = idx_reg;
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (last_pixel)
            begin
                idx_next = '0;
                sum_next = '0;
                cnt_next = '0;
            end
            else
            begin
                idx_next = in_line ? idx_reg + 1'b1 : idx_reg;
                sum_next = sum_acc;
                cnt_next = cnt_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

    assign line_done  = accept && last_pixel;
    assign line_sum   = sum_acc;
    assign line_count = cnt_acc;

endmodule
`default_nettype wire

// ===== src/lcs_back.sv =====
// Steering unit: divides each line record into a position, decides the drive and scales speeds.
`default_nettype none
module lcs_back #(
    parameter int SUM_W = 13,
    parameter int CNT_W = 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire lcs_pkg::cfg_t           cfg,
    input  wire lcs_pkg::fifo_status_t   line_status,
    input  wire logic [SUM_W+CNT_W-1:0]  line_rec,
    output logic                         line_pop,
    input  wire logic                    pop,
    output logic                         empty,
    output logic signed [7:0]            road_position,
    output logic [2:0]                   steer,
    output logic                         right_forward,
    output logic                         left_forward,
    output logic [9:0]                   right_speed,
    output logic [9:0]                   left_speed,
    output logic                         halt
);

    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int QW     = (SUM_W > 7) ? SUM_W : 7;
    localparam int CW     = (CNT_W > 8) ? CNT_W : 8;

    lcs_pkg::back_state_t state_reg, state_next;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]  div_reg, div_next;

    logic              rdir_reg, rdir_next;
    logic              ldir_reg, ldir_next;
    logic [3:0]        rten_reg, rten_next;
    logic [3:0]        lten_reg, lten_next;

    logic [7:0]        posf_reg, posf_next;
    logic [2:0]        steer_reg, steer_next;
    logic              halt_reg, halt_next;
    logic [13:0]       rprod_reg, rprod_next;
    logic [13:0]       lprod_reg, lprod_next;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_pos_reg, out_pos_next;
    logic [2:0]        out_steer_reg, out_steer_next;
    logic              out_rdir_reg, out_rdir_next;
    logic              out_ldir_reg, out_ldir_next;
    logic [9:0]        out_rspd_reg, out_rspd_next;
    logic [9:0]        out_lspd_reg, out_lspd_next;
    logic              out_halt_reg, out_halt_next;

    logic [CNT_W:0]    rem_shift;
    logic              q_bit;
    logic [QW-1:0]     quo_ext;
    logic [6:0]        pos;
    logic [CW-1:0]     cnt_ext;
    logic              out_free;
    logic              load_out;
    logic [26:0]       rscaled;
    logic [26:0]       lscaled;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lcs_pkg::BACK_IDLE:
            begin
                if (!line_status.empty)
                begin
                    state_next = lcs_pkg::BACK_DIVIDE;
                end
            end
            lcs_pkg::BACK_DIVIDE:
            begin
                if (step_reg == STEP_W'(1))
                begin
                    state_next = lcs_pkg::BACK_DECIDE;
                end
            end
            lcs_pkg::BACK_DECIDE:
            begin
                state_next = lcs_pkg::BACK_SCALE;
            end
            lcs_pkg::BACK_SCALE:
            begin
                if (out_free)
                begin
                    state_next = lcs_pkg::BACK_IDLE;
                end
            end
            default:
            begin
                state_next = lcs_pkg::BACK_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        out_free  = !out_valid_reg || pop;
        line_pop  = 1'b0;
        load_out  = 1'b0;

        // One quotient bit per cycle, restoring form.
        rem_shift = {rem_reg[CNT_W-1:0], dvd_reg[SUM_W-1]};
        q_bit     = (rem_shift >= {1'b0, div_reg});

        // The quotient is left in the dividend register when division ends.
        quo_ext   = QW'(dvd_reg);
        cnt_ext   = CW'(div_reg);
        if (div_reg == '0)
        begin
            pos = 7'd0;
        end
        else if (quo_ext > QW'(127))
        begin
            pos = 7'd127;
        end
        else
        begin
            pos = quo_ext[6:0];
        end

        step_next  = step_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        rdir_next  = rdir_reg;
        ldir_next  = ldir_reg;
        rten_next  = rten_reg;
        lten_next  = lten_reg;
        posf_next  = posf_reg;
        steer_next = steer_reg;
        halt_next  = halt_reg;
        rprod_next = rprod_reg;
        lprod_next = lprod_reg;

        rscaled = 27'(rprod_reg) * 27'(lcs_pkg::RECIP_TEN);
        lscaled = 27'(lprod_reg) * 27'(lcs_pkg::RECIP_TEN);

        unique case (state_reg)
            lcs_pkg::BACK_IDLE:
            begin
                if (!line_status.empty)
                begin
                    line_pop  = 1'b1;
                    dvd_next  = line_rec[SUM_W+CNT_W-1:CNT_W];
                    div_next  = line_rec[CNT_W-1:0];
                    rem_next  = '0;
                    step_next = STEP_W'(SUM_W);
                end
            end
            lcs_pkg::BACK_DIVIDE:
            begin
                rem_next  = q_bit ? rem_shift - {1'b0, div_reg} : rem_shift;
                dvd_next  = {dvd_reg[SUM_W-2:0], q_bit};
                step_next = step_reg - 1'b1;
            end
            lcs_pkg::BACK_DECIDE:
            begin
                posf_next = {1'b0, pos};
                halt_next = 1'b0;
                // Full white wins over every other case.
                if (cnt_ext > CW'(cfg.full_white_count))
                begin
                    rten_next  = lcs_pkg::TENTHS_STOP;
                    lten_next  = lcs_pkg::TENTHS_STOP;
                    steer_next = lcs_pkg::STEER_STOP;
                    halt_next  = 1'b1;
                end
                else if ((div_reg == '0) || (cnt_ext < CW'(cfg.min_bright)))
                begin
                    posf_next  = lcs_pkg::POSITION_LOST;
                    steer_next = lcs_pkg::STEER_HOLD;
                end
                else if (pos < cfg.left_edge)
                begin
                    rdir_next  = 1'b1;
                    ldir_next  = 1'b0;
                    rten_next  = lcs_pkg::TENTHS_FAST;
                    lten_next  = lcs_pkg::TENTHS_SLOW;
                    steer_next = lcs_pkg::STEER_LEFT;
                end
                else if (pos > cfg.right_edge)
                begin
                    rdir_next  = 1'b0;
                    ldir_next  = 1'b1;
                    rten_next  = lcs_pkg::TENTHS_SLOW;
                    lten_next  = lcs_pkg::TENTHS_FAST;
                    steer_next = lcs_pkg::STEER_RIGHT;
                end
                else
                begin
                    rdir_next  = 1'b1;
                    ldir_next  = 1'b1;
                    rten_next  = lcs_pkg::TENTHS_MID;
                    lten_next  = lcs_pkg::TENTHS_FAST;
                    steer_next = lcs_pkg::STEER_STRAIGHT;
                end
                rprod_next = 14'(rten_next) * 14'(cfg.motor_scale);
                lprod_next = 14'(lten_next) * 14'(cfg.motor_scale);
            end
            lcs_pkg::BACK_SCALE:
            begin
                load_out = out_free;
            end
            default:
            begin
                line_pop = 1'b0;
            end
        endcase

        out_valid_next = out_valid_reg;
        out_pos_next   = out_pos_reg;
        out_steer_next = out_steer_reg;
        out_rdir_next  = out_rdir_reg;
        out_ldir_next  = out_ldir_reg;
        out_rspd_next  = out_rspd_reg;
        out_lspd_next  = out_lspd_reg;
        out_halt_next  = out_halt_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_pos_next   = posf_reg;
            out_steer_next = steer_reg;
            out_rdir_next  = rdir_reg;
            out_ldir_next  = ldir_reg;
            out_rspd_next  = rscaled[25:16];
            out_lspd_next  = lscaled[25:16];
            out_halt_next  = halt_reg;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcs_pkg::BACK_IDLE;
            step_reg      <= '0;
            rdir_reg      <= 1'b0;
            ldir_reg      <= 1'b0;
            rten_reg      <= lcs_pkg::TENTHS_STOP;
            lten_reg      <= lcs_pkg::TENTHS_STOP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rdir_reg      <= rdir_next;
            ldir_reg      <= ldir_next;
            rten_reg      <= rten_next;
            lten_reg      <= lten_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        div_reg       <= div_next;
        posf_reg      <= posf_next;
        steer_reg     <= steer_next;
        halt_reg      <= halt_next;
        rprod_reg     <= rprod_next;
        lprod_reg     <= lprod_next;
        out_pos_reg   <= out_pos_next;
        out_steer_reg <= out_steer_next;
        out_rdir_reg  <= out_rdir_next;
        out_ldir_reg  <= out_ldir_next;
        out_rspd_reg  <= out_rspd_next;
        out_lspd_reg  <= out_lspd_next;
        out_halt_reg  <= out_halt_next;
    end

    assign empty         = !out_valid_reg;
    assign road_position = out_pos_reg;
    assign steer         = out_steer_reg;
    assign right_forward = out_rdir_reg;
    assign left_forward  = out_ldir_reg;
    assign right_speed   = out_rspd_reg;
    assign left_speed    = out_lspd_reg;
    assign halt          = out_halt_reg;

    // A held drive always reports a lost line.
    a_hold_means_lost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_steer_reg == lcs_pkg::STEER_HOLD)
            |-> (out_pos_reg == lcs_pkg::POSITION_LOST))
        else $error("hold result without lost position");

    // Halt is raised on a stop result and only there, and then the wheels stand still.
    a_halt_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_halt_reg == (out_steer_reg == lcs_pkg::STEER_STOP)))
        else $error("halt does not match stop result");

    a_stop_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_halt_reg |-> (out_rspd_reg == '0) && (out_lspd_reg == '0))
        else $error("wheels not stopped on halt");

endmodule
`default_nettype wire

// ===== src/line_centroid_steering.sv =====
// Top level of the line centroid steering block: configuration registers and unit wiring.
`default_nettype none
// A line-scan pixel beat is taken on each clock edge with push high and full low, one per
// cycle; the accumulator keeps a running sum of the indices of bright pixels and their count.
// The beat flagged last_pixel closes the line and hands its record to a two-entry queue. The
// steering unit pulls records from that queue one at a time: a restoring divider produces one
// quotient bit per cycle, then a decide step chooses the drive and a scale step computes the
// wheel speeds, which wait in the scale step until the result register is free. Lines of the
// default length stream without a stall, while a run of very short lines fills the queue and
// raises full until the divider catches up. Each line yields one result beat, shown while empty
// is low and taken with pop. A finished result waiting on pop does not stop pixel intake at
// once: the steering unit and the queue still take up to three more lines before full rises.
// The configuration port is always ready and its writes take effect on the next cycle;
// registers should be changed only while no line is in flight.
module line_centroid_steering #(
    parameter int LINE_PIXELS = lcs_pkg::LINE_PIXELS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [7:0]         pixel,
    input  wire logic               last_pixel,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [7:0]       road_position,
    output logic [2:0]              steer,
    output logic                    right_forward,
    output logic                    left_forward,
    output logic [9:0]              right_speed,
    output logic [9:0]              left_speed,
    output logic                    halt,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [9:0]         cfg_data
);

    // The index sum peaks when every pixel of a line is bright.
    localparam int SUM_W = $clog2(LINE_PIXELS * (LINE_PIXELS - 1) / 2 + 1);
    localparam int CNT_W = $clog2(LINE_PIXELS + 1);
    localparam int REC_W = SUM_W + CNT_W;

    lcs_pkg::cfg_t         cfg_reg, cfg_next;
    lcs_pkg::fifo_status_t line_status;

    logic             accept;
    logic             line_done;
    logic [SUM_W-1:0] line_sum;
    logic [CNT_W-1:0] line_count;
    logic [REC_W-1:0] line_rec;
    logic             line_pop;

    assign cfg_ready = 1'b1;

    // Register writes. Indexes past the last register are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lcs_pkg::REG_BRIGHT_THRESHOLD: cfg_next.bright_threshold = cfg_data[7:0];
                lcs_pkg::REG_MIN_BRIGHT:       cfg_next.min_bright       = cfg_data[7:0];
                lcs_pkg::REG_LEFT_EDGE:        cfg_next.left_edge        = cfg_data[6:0];
                lcs_pkg::REG_RIGHT_EDGE:       cfg_next.right_edge       = cfg_data[6:0];
                lcs_pkg::REG_FULL_WHITE_COUNT: cfg_next.full_white_count = cfg_data[7:0];
                lcs_pkg::REG_MOTOR_SCALE:      cfg_next.motor_scale      = cfg_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bright_threshold <= lcs_pkg::BRIGHT_THRESHOLD_RST;
            cfg_reg.min_bright       <= lcs_pkg::MIN_BRIGHT_RST;
            cfg_reg.left_edge        <= lcs_pkg::LEFT_EDGE_RST;
            cfg_reg.right_edge       <= lcs_pkg::RIGHT_EDGE_RST;
            cfg_reg.full_white_count <= lcs_pkg::FULL_WHITE_COUNT_RST;
            cfg_reg.motor_scale      <= lcs_pkg::MOTOR_SCALE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Any pixel is held off while the line queue has no room for a closing beat.
    assign full   = line_status.full;
    assign accept = push && !full;

    lcs_front #(
        .LINE_PIXELS (LINE_PIXELS),
        .SUM_W       (SUM_W),
        .CNT_W       (CNT_W)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .pixel            (pixel),
        .last_pixel       (last_pixel),
        .bright_threshold (cfg_reg.bright_threshold),
        .line_done        (line_done),
        .line_sum         (line_sum),
        .line_count       (line_count)
    );

    lcs_line_fifo #(
        .WIDTH (REC_W),
        .DEPTH (lcs_pkg::LINE_FIFO_DEPTH)
    ) u_line_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (line_done),
        .wr_data ({line_sum, line_count}),
        .rd_en   (line_pop),
        .rd_data (line_rec),
        .status  (line_status)
    );

    lcs_back #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .line_status   (line_status),
        .line_rec      (line_rec),
        .line_pop      (line_pop),
        .pop           (pop),
        .empty         (empty),
        .road_position (road_position),
        .steer         (steer),
        .right_forward (right_forward),
        .left_forward  (left_forward),
        .right_speed   (right_speed),
        .left_speed    (left_speed),
        .halt          (halt)
    );

endmodule
`default_nettype wire

// ===== bench/tb_line_centroid_steering.sv =====
// Self-checking bench for line_centroid_steering: pixel lines in, predicted drive beats checked.
`timescale 1ns / 1ps
module tb_line_centroid_steering;

    // Nothing may sit unaccepted on every port for this many cycles in a correct run.
    // The longest legal quiet stretch is the deliberate receiver hold-off below.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to let the divider and the result queue run dry before a register write.
    localparam int SETTLE_CYCLES  = 40;
    localparam int RX_HOLD_CYCLES = 400;
    // The directed lines before the random phases add roughly a hundred more pixels.
    localparam int RANDOM_ITEMS   = 650;
    localparam int LINES_PER_PHASE = 10;

    // One drive beat as the block presents it.
    typedef struct {
        logic signed [7:0] road_position;
        logic [2:0]        steer;
        logic              right_forward;
        logic              left_forward;
        logic [9:0]        right_speed;
        logic [9:0]        left_speed;
        logic              halt;
    } drive_beat_t;

    // How the pixels of a generated line are shaded against the threshold.
    typedef enum {
        SHADE_NOISE,
        SHADE_BLOB,
        SHADE_WHITE,
        SHADE_SPARSE,
        SHADE_EDGE
    } shade_t;

    // Predicts the drive beat of each line from its pixels and checks the block's beats
    // against the oldest prediction still waiting.
    class steering_predictor;
        lcs_pkg::cfg_t regs;
        int unsigned   line_pos;
        int unsigned   index_total;
        int unsigned   lit_count;
        logic          right_dir;
        logic          left_dir;
        logic [3:0]    right_tenths;
        logic [3:0]    left_tenths;
        drive_beat_t   pending_drives[$];
        int            errors;

        function new();
            regs.bright_threshold = lcs_pkg::BRIGHT_THRESHOLD_RST;
            regs.min_bright       = lcs_pkg::MIN_BRIGHT_RST;
            regs.left_edge        = lcs_pkg::LEFT_EDGE_RST;
            regs.right_edge       = lcs_pkg::RIGHT_EDGE_RST;
            regs.full_white_count = lcs_pkg::FULL_WHITE_COUNT_RST;
            regs.motor_scale      = lcs_pkg::MOTOR_SCALE_RST;
            line_pos     = 0;
            index_total  = 0;
            lit_count    = 0;
            right_dir    = 1'b0;
            left_dir     = 1'b0;
            right_tenths = lcs_pkg::TENTHS_STOP;
            left_tenths  = lcs_pkg::TENTHS_STOP;
            errors       = 0;
        endfunction

        function void take_config(lcs_pkg::reg_index_t idx, logic [9:0] val);
            case (idx)
                lcs_pkg::REG_BRIGHT_THRESHOLD: regs.bright_threshold = val[7:0];
                lcs_pkg::REG_MIN_BRIGHT:       regs.min_bright       = val[7:0];
                lcs_pkg::REG_LEFT_EDGE:        regs.left_edge        = val[6:0];
                lcs_pkg::REG_RIGHT_EDGE:       regs.right_edge       = val[6:0];
                lcs_pkg::REG_FULL_WHITE_COUNT: regs.full_white_count = val[7:0];
                lcs_pkg::REG_MOTOR_SCALE:      regs.motor_scale      = val;
                default: ;
            endcase
        endfunction

        function logic [9:0] wheel_speed(logic [3:0] tenths);
            int unsigned product;
            product = tenths * regs.motor_scale;
            return 10'(product / 10);
        endfunction

        function void take_pixel(logic [7:0] px, logic lst);
            int unsigned centroid;
            drive_beat_t d;
            // Pixels past the nominal line length are dropped until the line closes.
            if (line_pos < lcs_pkg::LINE_PIXELS_DEFAULT)
            begin
                if (px >= regs.bright_threshold)
                begin
                    index_total += line_pos;
                    lit_count   += 1;
                end
                line_pos += 1;
            end
            if (!lst)
                return;

            centroid = 0;
            if (lit_count != 0)
            begin
                centroid = index_total / lit_count;
                if (centroid > 127)
                    centroid = 127;
            end
            d.road_position = centroid[7:0];
            d.halt = 1'b0;

            // Full white wins over everything; the lost test follows; then the band.
            if (lit_count > regs.full_white_count)
            begin
                right_tenths = lcs_pkg::TENTHS_STOP;
                left_tenths  = lcs_pkg::TENTHS_STOP;
                d.steer = lcs_pkg::STEER_STOP;
                d.halt  = 1'b1;
            end
            else if (lit_count == 0 || lit_count < regs.min_bright)
            begin
                d.road_position = lcs_pkg::POSITION_LOST;
                d.steer = lcs_pkg::STEER_HOLD;
            end
            else if (centroid < regs.left_edge)
            begin
                right_dir = 1'b1;
                left_dir  = 1'b0;
                right_tenths = lcs_pkg::TENTHS_FAST;
                left_tenths  = lcs_pkg::TENTHS_SLOW;
                d.steer = lcs_pkg::STEER_LEFT;
            end
            else if (centroid > regs.right_edge)
            begin
                right_dir = 1'b0;
                left_dir  = 1'b1;
                right_tenths = lcs_pkg::TENTHS_SLOW;
                left_tenths  = lcs_pkg::TENTHS_FAST;
                d.steer = lcs_pkg::STEER_RIGHT;
            end
            else
            begin
                right_dir = 1'b1;
                left_dir  = 1'b1;
                right_tenths = lcs_pkg::TENTHS_MID;
                left_tenths  = lcs_pkg::TENTHS_FAST;
                d.steer = lcs_pkg::STEER_STRAIGHT;
            end
            d.right_forward = right_dir;
            d.left_forward  = left_dir;
            d.right_speed   = wheel_speed(right_tenths);
            d.left_speed    = wheel_speed(left_tenths);
            pending_drives.push_back(d);

            line_pos    = 0;
            index_total = 0;
            lit_count   = 0;
        endfunction

        function void compare_field(string name, logic [9:0] want, logic [9:0] seen);
            if (seen !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                errors++;
            end
        endfunction

        function void check_drive(drive_beat_t got);
            drive_beat_t want;
            if (pending_drives.size() == 0)
            begin
                $error("drive beat arrived with no line waiting for one");
                errors++;
                return;
            end
            want = pending_drives.pop_front();
            if (got.road_position !== want.road_position)
            begin
                $error("road_position: expected %0d, got %0d",
                       want.road_position, got.road_position);
                errors++;
            end
            compare_field("steer",         10'(want.steer),         10'(got.steer));
            compare_field("right_forward", 10'(want.right_forward), 10'(got.right_forward));
            compare_field("left_forward",  10'(want.left_forward),  10'(got.left_forward));
            compare_field("right_speed",   want.right_speed,        got.right_speed);
            compare_field("left_speed",    want.left_speed,         got.left_speed);
            compare_field("halt",          10'(want.halt),          10'(got.halt));
        endfunction

        function int waiting();
            return pending_drives.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [7:0]        pixel;
    logic              last_pixel;
    logic              empty;
    logic              pop;
    logic signed [7:0] road_position;
    logic [2:0]        steer;
    logic              right_forward;
    logic              left_forward;
    logic [9:0]        right_speed;
    logic [9:0]        left_speed;
    logic              halt;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_index;
    logic [9:0]        cfg_data;

    steering_predictor steering = new();

    // Sender and receiver pacing. tx_burst turns off sender gaps while it is set; rx_hold is a
    // long receiver hold-off requested by the stimulus and counted down by the receiver.
    bit tx_burst;
    int rx_hold;
    int rx_gap;
    int rx_free;
    int quiet_cycles;
    int random_items;

    line_centroid_steering #(
        .LINE_PIXELS(lcs_pkg::LINE_PIXELS_DEFAULT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel        (pixel),
        .last_pixel   (last_pixel),
        .empty        (empty),
        .pop          (pop),
        .road_position(road_position),
        .steer        (steer),
        .right_forward(right_forward),
        .left_forward (left_forward),
        .right_speed  (right_speed),
        .left_speed   (left_speed),
        .halt         (halt),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mostly back-to-back, often a few cycles, now and then a long gap.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one pixel beat and waits for the edge that takes it. The valid is only lowered
    // when a gap follows, so a back-to-back beat never sees push dropped and raised in one step.
    task automatic send_pixel(input logic [7:0] px, input logic lst);
        int gap;
        push       <= 1'b1;
        pixel      <= px;
        last_pixel <= lst;
        @(posedge clk);
        while (full)
            @(posedge clk);
        steering.take_pixel(px, lst);
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // The sender stops and waits for every predicted beat, then gives the divider and the
    // result queue time to go idle so a register write cannot land on a line in flight.
    task automatic settle_block();
        push <= 1'b0;
        while (steering.waiting() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all six registers, one beat each, in index order.
    task automatic load_config(input lcs_pkg::cfg_t c);
        lcs_pkg::reg_index_t idx;
        logic [9:0]          val;
        idx = idx.first();
        forever
        begin
            case (idx)
                lcs_pkg::REG_BRIGHT_THRESHOLD: val = 10'(c.bright_threshold);
                lcs_pkg::REG_MIN_BRIGHT:       val = 10'(c.min_bright);
                lcs_pkg::REG_LEFT_EDGE:        val = 10'(c.left_edge);
                lcs_pkg::REG_RIGHT_EDGE:       val = 10'(c.right_edge);
                lcs_pkg::REG_FULL_WHITE_COUNT: val = 10'(c.full_white_count);
                default:                       val = c.motor_scale;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            steering.take_config(idx, val);
            if (idx == idx.last())
                break;
            idx = idx.next();
        end
        cfg_valid <= 1'b0;
    endtask

    // Random settings, biased so that short lines still reach the band edges, the
    // full-white stop and the lost case fairly often.
    function automatic lcs_pkg::cfg_t random_config();
        lcs_pkg::cfg_t c;
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            c.bright_threshold = 8'd0;
        else if (r < 25)
            c.bright_threshold = 8'd255;
        else
            c.bright_threshold = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0)
            c.min_bright = 8'($urandom_range(0, 8));
        else
            c.min_bright = 8'($urandom_range(0, 128));
        if ($urandom_range(0, 1) == 0)
        begin
            c.left_edge  = 7'($urandom_range(0, 16));
            c.right_edge = 7'($urandom_range(0, 20));
        end
        else
        begin
            c.left_edge  = 7'($urandom_range(0, 127));
            c.right_edge = 7'($urandom_range(0, 127));
        end
        r = $urandom_range(0, 99);
        if (r < 40)
            c.full_white_count = 8'($urandom_range(0, 12));
        else if (r < 60)
            c.full_white_count = 8'd128;
        else
            c.full_white_count = 8'($urandom_range(0, 128));
        r = $urandom_range(0, 99);
        if (r < 20)
            c.motor_scale = 10'd1023;
        else if (r < 30)
            c.motor_scale = 10'd0;
        else
            c.motor_scale = 10'($urandom_range(0, 1023));
        return c;
    endfunction

    function automatic logic [7:0] lit_value(logic [7:0] thr);
        return 8'($urandom_range(thr, 255));
    endfunction

    function automatic logic [7:0] dim_value(logic [7:0] thr);
        // With a zero threshold every value counts as lit; any value will do.
        if (thr == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, thr - 1));
    endfunction

    // One line of random length and shading. Most lines are short so that results come
    // often; some have the full nominal length and a few run past it.
    task automatic send_random_line();
        int            len;
        int            r;
        int            blob_lo;
        int            blob_hi;
        shade_t        shade;
        logic [7:0]    thr;
        logic [7:0]    px;
        r = $urandom_range(0, 99);
        if (r < 55)
            len = $urandom_range(1, 12);
        else if (r < 80)
            len = $urandom_range(13, lcs_pkg::LINE_PIXELS_DEFAULT - 1);
        else if (r < 92)
            len = lcs_pkg::LINE_PIXELS_DEFAULT;
        else
            len = $urandom_range(lcs_pkg::LINE_PIXELS_DEFAULT + 1,
                                 lcs_pkg::LINE_PIXELS_DEFAULT + 32);
        shade   = shade_t'($urandom_range(0, 4));
        blob_lo = $urandom_range(0, len - 1);
        blob_hi = blob_lo + $urandom_range(0, 40);
        tx_burst = ($urandom_range(0, 3) == 0);
        thr = steering.regs.bright_threshold;
        for (int i = 0; i < len; i++)
        begin
            case (shade)
                SHADE_BLOB:   px = (i >= blob_lo && i <= blob_hi) ? lit_value(thr)
                                                                  : dim_value(thr);
                SHADE_WHITE:  px = lit_value(thr);
                SHADE_SPARSE: px = ($urandom_range(0, 9) == 0) ? lit_value(thr)
                                                               : dim_value(thr);
                SHADE_EDGE:   px = ($urandom_range(0, 1) == 0 || thr == 8'd0) ? thr
                                                                              : thr - 8'd1;
                default:      px = 8'($urandom_range(0, 255));
            endcase
            send_pixel(px, (i == len - 1));
        end
        random_items += len;
        tx_burst = 1'b0;
    endtask

    // Receiver: checks each accepted drive beat at the edge that takes it, then decides pop
    // for the next cycle. A requested hold-off takes priority over the random gaps.
    initial
    begin
        drive_beat_t got;
        pop     <= 1'b0;
        rx_gap  = 0;
        rx_free = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got.road_position = road_position;
                got.steer         = steer;
                got.right_forward = right_forward;
                got.left_forward  = left_forward;
                got.right_speed   = right_speed;
                got.left_speed    = left_speed;
                got.halt          = halt;
                steering.check_drive(got);
                if (rx_free > 0)
                begin
                    rx_free--;
                    rx_gap = 0;
                end
                else
                begin
                    rx_gap = pick_gap();
                    if ($urandom_range(0, 19) == 0)
                        rx_free = $urandom_range(10, 40);
                end
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                pop <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: any accepted beat on any port restarts the count.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        push       <= 1'b0;
        pixel      <= 8'd0;
        last_pixel <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= lcs_pkg::REG_BRIGHT_THRESHOLD;
        cfg_data   <= 10'd0;
        tx_burst     = 1'b0;
        rx_hold      = 0;
        quiet_cycles = 0;
        random_items = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings. A dark one-pixel line is lost and repeats the all-zero reset drive.
        send_pixel(8'd0, 1'b1);
        // Exactly min_bright full-scale pixels: a valid position near the left end.
        repeat (4) send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b1);
        // Pixels on and just under the threshold, with the closing pixel counted too.
        send_pixel(8'd150, 1'b0);
        send_pixel(8'd149, 1'b0);
        repeat (3) send_pixel(8'd150, 1'b0);
        send_pixel(8'd150, 1'b1);

        // Everything lit, widest wheel scale, a one-wide band: left, straight and right.
        settle_block();
        load_config('{8'd0, 8'd0, 7'd1, 7'd1, 8'd128, 10'd1023});
        send_pixel(8'd0, 1'b1);
        repeat (2) send_pixel(8'($urandom_range(0, 255)), 1'b0);
        send_pixel(8'($urandom_range(0, 255)), 1'b1);
        repeat (4) send_pixel(8'($urandom_range(0, 255)), 1'b0);
        send_pixel(8'($urandom_range(0, 255)), 1'b1);

        // Opposite extremes with crossed edges: one lit pixel is already full white, and a
        // dark line with nothing lit is lost rather than stopped.
        settle_block();
        load_config('{8'd255, 8'd128, 7'd127, 7'd0, 8'd0, 10'd0});
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd254, 1'b1);

        // Crossed edges with a valid line: the left test wins. Then a dark line with
        // min_bright zero is still lost and holds the left drive.
        settle_block();
        load_config('{8'd128, 8'd0, 7'd127, 7'd0, 8'd128, 10'd555});
        send_pixel(8'd200, 1'b1);
        send_pixel(8'd127, 1'b1);

        // Receiver holds off while short lines keep coming, so the line queue fills and full
        // stalls the sender; afterwards the sender waits for every result before going on.
        settle_block();
        load_config(random_config());
        rx_hold = RX_HOLD_CYCLES;
        tx_burst = 1'b1;
        repeat (30)
        begin
            repeat ($urandom_range(0, 2)) send_pixel(8'($urandom_range(0, 255)), 1'b0);
            send_pixel(8'($urandom_range(0, 255)), 1'b1);
        end
        tx_burst = 1'b0;

        // Random phases, each under fresh settings written while the block is idle.
        while (random_items < RANDOM_ITEMS)
        begin
            settle_block();
            load_config(random_config());
            for (int n = 0; n < LINES_PER_PHASE && random_items < RANDOM_ITEMS; n++)
            begin
                send_random_line();
            end
        end

        settle_block();
        if (steering.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
